FILE: rtl/assert_macros.svh
// Assertion macros shared by the interpolator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define ASSERT_CLKRST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("interpolator assertion failed");
// Check a property on every clock edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("interpolator assertion failed");
`else
`define ASSERT_CLKRST(label, clk, rst_n, prop)
`define ASSERT_CLK(label, clk, prop)
`endif
`endif

FILE: rtl/tvi_pkg.sv
// Types, constants and helper functions of the trilinear vector interpolator.
`timescale 1ns / 1ps
package tvi_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_CORNERS = 8;
    localparam int NUM_COMP    = 3;
    localparam int CORNER_W    = NUM_COMP * COORD_WIDTH;
    localparam int CFG_IDX_W   = $clog2(NUM_CORNERS);

    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;
    typedef logic [CORNER_W-1:0]        t_corner;
    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic [FRAC_BITS:0]         t_frac;

    localparam t_frac FRAC_ONE = t_frac'(1) << FRAC_BITS;

    // Register indexes of the corner registers
    localparam t_cfg_idx CORNER_000 = t_cfg_idx'(0);
    localparam t_cfg_idx CORNER_100 = t_cfg_idx'(1);
    localparam t_cfg_idx CORNER_010 = t_cfg_idx'(2);
    localparam t_cfg_idx CORNER_110 = t_cfg_idx'(3);
    localparam t_cfg_idx CORNER_001 = t_cfg_idx'(4);
    localparam t_cfg_idx CORNER_101 = t_cfg_idx'(5);
    localparam t_cfg_idx CORNER_011 = t_cfg_idx'(6);
    localparam t_cfg_idx CORNER_111 = t_cfg_idx'(7);

    typedef struct packed {
        t_frac frac_u;
        t_frac frac_v;
        t_frac frac_w;
    } t_in_item;

    typedef struct packed {
        t_coord x_out;
        t_coord y_out;
        t_coord z_out;
    } t_out_item;

    // Extract one signed coordinate from a packed corner
    function automatic t_coord coord_of(input t_corner corner, input int comp);
        coord_of = t_coord'(corner[comp*COORD_WIDTH +: COORD_WIDTH]);
    endfunction

    // Clamp a fraction to 1.0
    function automatic t_frac sat_frac(input t_frac f);
        sat_frac = (f > FRAC_ONE) ? FRAC_ONE : f;
    endfunction

endpackage

FILE: rtl/tvi_cfg.sv
// Corner register file written through the configuration channel.
`timescale 1ns / 1ps
module tvi_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  tvi_pkg::t_cfg_idx    i_cfg_index,
    input  tvi_pkg::t_corner     i_cfg_data,
    output logic                 o_cfg_ready,
    output tvi_pkg::t_corner     o_corner [tvi_pkg::NUM_CORNERS]
);
    import tvi_pkg::*;

    t_corner r_corner [NUM_CORNERS];

    // Take every write at once
    assign o_cfg_ready = 1'b1;

    // Store the written corner, clear all corners on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CORNERS; i++) begin
                r_corner[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            r_corner[i_cfg_index] <= i_cfg_data;
        end
    end

    assign o_corner = r_corner;

endmodule

FILE: rtl/tvi_lerp.sv
// Two-stage bank of parallel lerps: multiply, then floor-shift and add.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tvi_lerp #(
    parameter int LANES = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  tvi_pkg::t_coord i_a [LANES],
    input  tvi_pkg::t_coord i_b [LANES],
    input  tvi_pkg::t_frac  i_t,
    output logic            o_valid,
    output tvi_pkg::t_coord o_res [LANES]
);
    import tvi_pkg::*;

    localparam int PW = COORD_WIDTH + FRAC_BITS + 3;

    logic signed [COORD_WIDTH:0]  n_diff [LANES];
    logic signed [FRAC_BITS+1:0]  n_t;
    logic signed [PW-1:0]         n_prod [LANES];
    t_coord                       n_res  [LANES];

    logic                         r_val_m;
    logic                         r_val_o;
    t_coord                       r_a    [LANES];
    t_coord                       r_b    [LANES];
    logic signed [PW-1:0]         r_prod [LANES];
    t_coord                       r_res  [LANES];

    // Form (b - a) * t per lane
    always_comb begin
        n_t = $signed({1'b0, i_t});
        for (int l = 0; l < LANES; l++) begin
            n_diff[l] = $signed({i_b[l][COORD_WIDTH-1], i_b[l]})
                      - $signed({i_a[l][COORD_WIDTH-1], i_a[l]});
            n_prod[l] = n_diff[l] * n_t;
        end
    end

    // Floor-divide by one and add the start point; the result stays within a..b
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_res[l] = r_a[l] + t_coord'(r_prod[l][FRAC_BITS +: COORD_WIDTH]);
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val_m <= 1'b0;
            r_val_o <= 1'b0;
        end else begin
            r_val_m <= i_valid;
            r_val_o <= r_val_m;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        r_a    <= i_a;
        r_b    <= i_b;
        r_prod <= n_prod;
        r_res  <= n_res;
    end

    assign o_valid = r_val_o;
    assign o_res   = r_res;

    `ASSERT_CLKRST(a_lerp_latency, i_clk, i_rst_n, r_val_o |-> $past(i_valid, 2))

    for (genvar l = 0; l < LANES; l++) begin : g_chk
        `ASSERT_CLKRST(a_prod_sign, i_clk, i_rst_n, (r_val_m && (r_b[l] >= r_a[l])) |-> !r_prod[l][PW-1])
        `ASSERT_CLKRST(a_res_bound, i_clk, i_rst_n, r_val_o |-> (($past(r_a[l]) <= r_res[l] && r_res[l] <= $past(r_b[l])) || ($past(r_b[l]) <= r_res[l] && r_res[l] <= $past(r_a[l]))))
    end

endmodule

FILE: rtl/trilinear_vector_interpolator.sv
// Top level of the trilinear vector interpolator.
//
// Usage:
//   Corners are written on the configuration channel (i_cfg_valid, o_cfg_ready,
//   i_cfg_index, i_cfg_data). Index 0..7 selects corner_000, _100, _010, _110,
//   _001, _101, _011, _111; each holds x, y, z as signed 16-bit fields packed
//   low to high. o_cfg_ready is always high; write corners only while no query
//   is in flight.
//   A query transaction (fractions u, v, w in Q1.16, clamped to 1.0) is taken
//   at each rising edge with i_start high and o_busy low. o_busy stays low, so
//   one query can enter every cycle.
//   Each query yields one result transaction on o_out, marked by o_out_valid
//   for one cycle. Between the accepting edge and that strobe lie the input
//   register, which loads at acceptance, then three two-stage lerp banks
//   (12 lerps along u, 6 along v, 3 along w), each bank a multiply stage and
//   a shift-add stage.
//   Throughput is one query per cycle, set by the fully pipelined lerp banks.
//   Reset clears the corners to zero and drops all queries in flight.
//   The receiver takes every result in its strobe cycle; there is no stall.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module trilinear_vector_interpolator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  tvi_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    output tvi_pkg::t_out_item o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  tvi_pkg::t_cfg_idx  i_cfg_index,
    input  tvi_pkg::t_corner   i_cfg_data
);
    import tvi_pkg::*;

    localparam int LANES_U = 4 * NUM_COMP;
    localparam int LANES_V = 2 * NUM_COMP;
    localparam int LANES_W = NUM_COMP;
    localparam int LATENCY = 7;

    logic     acc;
    t_corner  corner [NUM_CORNERS];

    logic     r_in_valid;
    t_frac    r_u;
    t_frac    r_v;
    t_frac    r_w;
    t_frac    r_v_pipe [2];
    t_frac    r_w_pipe [4];

    t_coord   u_a [LANES_U];
    t_coord   u_b [LANES_U];
    t_coord   e   [LANES_U];
    logic     e_valid;
    t_coord   v_a [LANES_V];
    t_coord   v_b [LANES_V];
    t_coord   f   [LANES_V];
    logic     f_valid;
    t_coord   w_a [LANES_W];
    t_coord   w_b [LANES_W];
    t_coord   res [LANES_W];
    logic     res_valid;

    assign o_busy = 1'b0;
    assign acc    = i_start && !o_busy;

    tvi_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_corner    (corner)
    );

    // Register the query, clamping fractions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_u <= sat_frac(i_in.frac_u);
        r_v <= sat_frac(i_in.frac_v);
        r_w <= sat_frac(i_in.frac_w);
    end

    // Delay v and w to meet their lerp banks
    always_ff @(posedge i_clk) begin
        r_v_pipe[0] <= r_v;
        r_v_pipe[1] <= r_v_pipe[0];
        r_w_pipe[0] <= r_w;
        r_w_pipe[1] <= r_w_pipe[0];
        r_w_pipe[2] <= r_w_pipe[1];
        r_w_pipe[3] <= r_w_pipe[2];
    end

    // Route corner pairs and partial results to the lanes of each bank
    for (genvar c = 0; c < NUM_COMP; c++) begin : g_route
        assign u_a[c*4+0] = coord_of(corner[CORNER_000], c);
        assign u_b[c*4+0] = coord_of(corner[CORNER_100], c);
        assign u_a[c*4+1] = coord_of(corner[CORNER_010], c);
        assign u_b[c*4+1] = coord_of(corner[CORNER_110], c);
        assign u_a[c*4+2] = coord_of(corner[CORNER_001], c);
        assign u_b[c*4+2] = coord_of(corner[CORNER_101], c);
        assign u_a[c*4+3] = coord_of(corner[CORNER_011], c);
        assign u_b[c*4+3] = coord_of(corner[CORNER_111], c);

        assign v_a[c*2+0] = e[c*4+0];
        assign v_b[c*2+0] = e[c*4+1];
        assign v_a[c*2+1] = e[c*4+2];
        assign v_b[c*2+1] = e[c*4+3];

        assign w_a[c] = f[c*2+0];
        assign w_b[c] = f[c*2+1];
    end

    tvi_lerp #(.LANES(LANES_U)) u_lerp_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_a     (u_a),
        .i_b     (u_b),
        .i_t     (r_u),
        .o_valid (e_valid),
        .o_res   (e)
    );

    tvi_lerp #(.LANES(LANES_V)) u_lerp_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (e_valid),
        .i_a     (v_a),
        .i_b     (v_b),
        .i_t     (r_v_pipe[1]),
        .o_valid (f_valid),
        .o_res   (f)
    );

    tvi_lerp #(.LANES(LANES_W)) u_lerp_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_t     (r_w_pipe[3]),
        .o_valid (res_valid),
        .o_res   (res)
    );

    // Drive the result transaction
    assign o_out_valid = res_valid;
    assign o_out.x_out = res[0];
    assign o_out.y_out = res[1];
    assign o_out.z_out = res[2];

    `ASSERT_CLKRST(a_out_latency, i_clk, i_rst_n, o_out_valid |-> $past(acc, LATENCY))
    `ASSERT_CLKRST(a_frac_clamped, i_clk, i_rst_n, r_in_valid |-> (r_u <= FRAC_ONE && r_v <= FRAC_ONE && r_w <= FRAC_ONE))
    `ASSERT_CLK(a_reset_flush, i_clk, !i_rst_n |=> !r_in_valid && !e_valid && !f_valid && !o_out_valid)

endmodule
